FILE: rtl/ilsplit_pkg.sv
// Shared types and constants for the IRC line field splitter.
// Request payload structs, character codes, command classes, keyword table.
// No dependencies.
package ilsplit_pkg;

    localparam int MAX_LINE_DEF = 512;
    localparam int FIELD_W      = 9;
    localparam int KW_COUNT     = 7;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;

    // Command classes
    localparam logic [3:0] KIND_OTHER   = 4'd0;
    localparam logic [3:0] KIND_NUMERIC = 4'd1;
    localparam logic [3:0] KIND_PING    = 4'd2;
    localparam logic [3:0] KIND_PRIVMSG = 4'd3;
    localparam logic [3:0] KIND_NOTICE  = 4'd4;
    localparam logic [3:0] KIND_JOIN    = 4'd5;
    localparam logic [3:0] KIND_PART    = 4'd6;
    localparam logic [3:0] KIND_QUIT    = 4'd7;
    localparam logic [3:0] KIND_NICK    = 4'd8;

    // Present mask bits
    localparam int PM_SOURCE  = 0;
    localparam int PM_USER    = 1;
    localparam int PM_HOST    = 2;
    localparam int PM_TARGET  = 3;
    localparam int PM_MESSAGE = 4;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
    } line_req_t;

    typedef struct packed {
        logic               parse_ok;
        logic [3:0]         command_kind;
        logic [4:0]         present_mask;
        logic [FIELD_W-1:0] nick_len;
        logic [FIELD_W-1:0] user_len;
        logic [FIELD_W-1:0] host_len;
        logic [FIELD_W-1:0] command_start;
        logic [FIELD_W-1:0] command_len;
        logic [FIELD_W-1:0] target_start;
        logic [FIELD_W-1:0] target_len;
        logic [FIELD_W-1:0] message_start;
        logic [FIELD_W-1:0] message_len;
    } result_req_t;

    // Keyword j in match order: PING PRIVMSG NOTICE JOIN PART QUIT NICK
    function automatic logic [2:0] kw_len(input logic [2:0] j);
        logic [2:0] len;
        case (j)
            3'd0:    len = 3'd4;
            3'd1:    len = 3'd7;
            3'd2:    len = 3'd6;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] j, input logic [2:0] k);
        logic [55:0] word;
        int          sel;
        case (j)
            3'd0:    word = {"PING", 24'h0};
            3'd1:    word = "PRIVMSG";
            3'd2:    word = {"NOTICE", 8'h0};
            3'd3:    word = {"JOIN", 24'h0};
            3'd4:    word = {"PART", 24'h0};
            3'd5:    word = {"QUIT", 24'h0};
            3'd6:    word = {"NICK", 24'h0};
            default: word = '0;
        endcase
        sel = (k > 3'd6) ? 0 : (6 - int'(k));
        return word[sel*8 +: 8];
    endfunction

endpackage

FILE: rtl/ilsplit_in_if.sv
// Byte request channel of the IRC line field splitter.
// Depends on ilsplit_pkg.
interface ilsplit_in_if;
    logic                   valid;
    logic                   ready;
    ilsplit_pkg::line_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ilsplit_out_if.sv
// Result request channel of the IRC line field splitter.
// Depends on ilsplit_pkg.
interface ilsplit_out_if;
    logic                     valid;
    logic                     ready;
    ilsplit_pkg::result_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/irc_line_field_splitter.sv
// IRC line field splitter, top level.
// Depends on ilsplit_pkg, ilsplit_in_if and ilsplit_out_if.
//
// Usage:
//   line   : one request per line byte (line_byte, line_last). A zero byte or
//            MAX_LINE-1 kept bytes ends the text; later bytes up to the one
//            flagged last are dropped. One byte is taken every clock while line.ready is high.
//   result : one request per line, issued for the byte flagged last. It holds
//            parse_ok, the command class, presence bits and the offsets and
//            lengths of prefix parts, command, target and message.
// Each byte walks a small phase machine that keeps running offsets, so the
// parse is complete when the last byte arrives. At every newline the running
// state is copied to a snapshot; if a newline was kept, the result reports
// the snapshot of the last one, i.e. the text before it.
// The result passes through the final-state register, then the result
// register, after the last byte is accepted. Throughput: one byte per
// clock, back to back across lines; the only limit is the single-entry
// result register plus the final-state register acting as skid stage.
// Reset: all parse state returns to line start; no result is pending.
// Stall: with result.ready low, one finished line waits in the result
// register and one in the final-state register; line.ready then drops.
module irc_line_field_splitter #(
    parameter int MAX_LINE = ilsplit_pkg::MAX_LINE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ilsplit_in_if.sink           line,
    ilsplit_out_if.source        result
);
    import ilsplit_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE);

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [6:0] {
        PH_START     = 7'b0000001,
        PH_PREFIX    = 7'b0000010,
        PH_CMD       = 7'b0000100,
        PH_TGT_FIRST = 7'b0001000,
        PH_TGT       = 7'b0010000,
        PH_MSG_FIRST = 7'b0100000,
        PH_MSG       = 7'b1000000
    } phase_t;

    // Leading-number scan of the command token
    typedef enum logic [2:0] {
        NUM_WS   = 3'b001,
        NUM_DIG  = 3'b010,
        NUM_STOP = 3'b100
    } num_t;

    typedef struct packed {
        phase_t              phase;
        logic                src;
        logic                bang_seen;
        logic                at_seen;
        pos_t                bang_pos;
        pos_t                at_pos;
        pos_t                nick;
        pos_t                ul;
        pos_t                hl;
        pos_t                cs;
        pos_t                cl;
        pos_t                t;
        logic                hash;
        logic                tgt_colon;
        pos_t                tl;
        pos_t                ms;
        num_t                num;
        logic                nonzero;
        logic [KW_COUNT-1:0] kw_match;
        logic [2:0]          cmd_cnt;
        pos_t                n;
    } pstate_t;

    function automatic pstate_t start_state();
        pstate_t s;
        s          = '0;
        s.phase    = PH_START;
        s.num      = NUM_WS;
        s.kw_match = '1;
        return s;
    endfunction

    pstate_t     st_reg;
    pstate_t     snap_reg;
    pstate_t     fin_reg;
    logic        ended_reg;
    logic        seen_reg;
    logic        fin_valid_reg;
    result_req_t res_reg;
    logic        res_valid_reg;

    pstate_t     st_step;
    pstate_t     st_after;
    result_req_t res_next;
    logic [7:0]  b;
    logic        in_acc;
    logic        last;
    logic        keep;
    logic        is_nl;
    logic        cmd_byte;
    logic        fin_adv;
    logic        ended_next;

    assign b       = line.data.line_byte;
    assign last    = line.data.line_last;
    assign in_acc  = line.valid && line.ready;
    assign keep    = in_acc && !ended_reg && (b != CH_NUL);
    assign is_nl   = keep && (b == CH_NL);
    assign fin_adv = fin_valid_reg && (!res_valid_reg || result.ready);

    assign line.ready   = !fin_valid_reg || fin_adv;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // Per-byte phase step; taken only for kept bytes
    always_comb
    begin
        logic is_ws;
        logic is_dig;
        pos_t p;
        st_step  = st_reg;
        p        = st_reg.n;
        cmd_byte = 1'b0;
        unique case (st_reg.phase)
            PH_START:
            begin
                if (b == CH_COLON)
                begin
                    st_step.phase = PH_PREFIX;
                    st_step.src   = 1'b1;
                end
                else if (b == CH_SPACE)
                begin
                    st_step.cl    = '0;
                    st_step.t     = p + pos_t'(1);
                    st_step.phase = PH_TGT_FIRST;
                end
                else
                begin
                    st_step.phase = PH_CMD;
                    cmd_byte      = 1'b1;
                end
            end
            PH_PREFIX:
            begin
                if (b == CH_SPACE)
                begin
                    st_step.cs    = p + pos_t'(1);
                    st_step.phase = PH_CMD;
                    if (st_reg.bang_seen)
                    begin
                        st_step.nick = st_reg.bang_pos - pos_t'(1);
                        if (st_reg.at_seen)
                        begin
                            st_step.ul = st_reg.at_pos - st_reg.bang_pos - pos_t'(1);
                            st_step.hl = p - st_reg.at_pos - pos_t'(1);
                        end
                        else
                        begin
                            st_step.ul = p - st_reg.bang_pos - pos_t'(1);
                        end
                    end
                    else
                    begin
                        st_step.nick = p - pos_t'(1);
                    end
                end
                else if (b == CH_BANG && !st_reg.bang_seen)
                begin
                    st_step.bang_seen = 1'b1;
                    st_step.bang_pos  = p;
                end
                else if (b == CH_AT && st_reg.bang_seen && !st_reg.at_seen)
                begin
                    st_step.at_seen = 1'b1;
                    st_step.at_pos  = p;
                end
            end
            PH_CMD:
            begin
                if (b == CH_SPACE)
                begin
                    st_step.cl    = p - st_reg.cs;
                    st_step.t     = p + pos_t'(1);
                    st_step.phase = PH_TGT_FIRST;
                end
                else
                begin
                    cmd_byte = 1'b1;
                end
            end
            PH_TGT_FIRST:
            begin
                if (b == CH_COLON)
                begin
                    st_step.ms        = p + pos_t'(1);
                    st_step.tgt_colon = 1'b1;
                    st_step.phase     = PH_MSG;
                end
                else if (b == CH_SPACE)
                begin
                    st_step.tl    = '0;
                    st_step.phase = PH_MSG_FIRST;
                end
                else
                begin
                    st_step.hash  = (b == CH_HASH);
                    st_step.phase = PH_TGT;
                end
            end
            PH_TGT:
            begin
                if (b == CH_SPACE)
                begin
                    st_step.tl    = p - st_reg.t;
                    st_step.phase = PH_MSG_FIRST;
                end
            end
            PH_MSG_FIRST:
            begin
                st_step.ms    = (b == CH_COLON) ? p + pos_t'(1) : p;
                st_step.phase = PH_MSG;
            end
            PH_MSG:
            begin
            end
            default:
            begin
            end
        endcase

        // Command classification, one token byte at a time
        is_ws  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
        if (cmd_byte)
        begin
            unique case (st_reg.num)
                NUM_WS:
                begin
                    if (is_dig)
                    begin
                        st_step.num     = NUM_DIG;
                        st_step.nonzero = st_reg.nonzero || (b != CH_ZERO);
                    end
                    else if (b == CH_PLUS || b == CH_MINUS)
                        st_step.num = NUM_DIG;
                    else if (!is_ws)
                        st_step.num = NUM_STOP;
                end
                NUM_DIG:
                begin
                    if (is_dig)
                        st_step.nonzero = st_reg.nonzero || (b != CH_ZERO);
                    else
                        st_step.num = NUM_STOP;
                end
                NUM_STOP:
                begin
                end
                default:
                begin
                end
            endcase
            for (int j = 0; j < KW_COUNT; j++)
            begin
                if (st_reg.cmd_cnt < kw_len(3'(j)) && b != kw_char(3'(j), st_reg.cmd_cnt))
                    st_step.kw_match[j] = 1'b0;
            end
            if (st_reg.cmd_cnt != 3'd7)
                st_step.cmd_cnt = st_reg.cmd_cnt + 3'd1;
        end
        st_step.n = p + pos_t'(1);
    end

    assign st_after   = keep ? st_step : st_reg;
    assign ended_next = ended_reg || (in_acc && b == CH_NUL)
                        || (keep && (st_reg.n + pos_t'(1)) == pos_t'(MAX_LINE - 1));

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= start_state();
            ended_reg <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            if (last)
            begin
                st_reg    <= start_state();
                ended_reg <= 1'b0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                st_reg    <= st_after;
                ended_reg <= ended_next;
                if (is_nl)
                    seen_reg <= 1'b1;
            end
        end
    end

    // Newline snapshot: state just before the newline byte
    always_ff @(posedge clk)
    begin
        if (is_nl)
            snap_reg <= st_reg;
    end

    // Final state of a finished line
    always_ff @(posedge clk)
    begin
        if (in_acc && last)
        begin
            if (is_nl)
                fin_reg <= st_reg;
            else if (seen_reg)
                fin_reg <= snap_reg;
            else
                fin_reg <= st_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (in_acc && last)
            fin_valid_reg <= 1'b1;
        else if (fin_adv)
            fin_valid_reg <= 1'b0;
    end

    // Close out the parse at the text end held in fin_reg.n
    always_comb
    begin
        logic ok;
        logic tgt_none;
        pos_t tlen;
        pos_t mlen;
        res_next = '0;
        ok = (fin_reg.phase == PH_TGT_FIRST) || (fin_reg.phase == PH_TGT)
             || (fin_reg.phase == PH_MSG_FIRST) || (fin_reg.phase == PH_MSG);
        tlen     = (fin_reg.phase == PH_TGT) ? fin_reg.n - fin_reg.t : fin_reg.tl;
        mlen     = fin_reg.n - fin_reg.ms;
        tgt_none = (fin_reg.phase == PH_MSG) && fin_reg.tgt_colon;
        if (ok)
        begin
            res_next.parse_ok              = 1'b1;
            res_next.present_mask[PM_SOURCE] = fin_reg.src;
            res_next.present_mask[PM_USER]   = fin_reg.bang_seen;
            res_next.present_mask[PM_HOST]   = fin_reg.at_seen;
            res_next.nick_len      = FIELD_W'(fin_reg.nick);
            res_next.user_len      = FIELD_W'(fin_reg.ul);
            res_next.host_len      = FIELD_W'(fin_reg.hl);
            res_next.command_start = FIELD_W'(fin_reg.cs);
            res_next.command_len   = FIELD_W'(fin_reg.cl);

            if (!tgt_none && fin_reg.hash)
            begin
                res_next.present_mask[PM_TARGET] = 1'b1;
                res_next.target_start = FIELD_W'(fin_reg.t);
                res_next.target_len   = FIELD_W'(tlen);
            end
            else if (!tgt_none && fin_reg.src)
            begin
                // Non-channel target: report the source nickname instead
                res_next.present_mask[PM_TARGET] = 1'b1;
                res_next.target_start = FIELD_W'(1);
                res_next.target_len   = FIELD_W'(fin_reg.nick);
            end

            if (fin_reg.phase == PH_MSG_FIRST)
            begin
                res_next.present_mask[PM_MESSAGE] = 1'b1;
                res_next.message_start = FIELD_W'(fin_reg.n);
            end
            else if (fin_reg.phase == PH_MSG)
            begin
                res_next.present_mask[PM_MESSAGE] = 1'b1;
                res_next.message_start = FIELD_W'(fin_reg.ms);
                res_next.message_len   = FIELD_W'(mlen);
            end

            // Lowest keyword index wins; numeric beats all keywords
            res_next.command_kind = KIND_OTHER;
            for (int j = KW_COUNT - 1; j >= 0; j--)
            begin
                if (fin_reg.kw_match[j] && fin_reg.cmd_cnt >= kw_len(3'(j)))
                    res_next.command_kind = KIND_PING + 4'(j);
            end
            if (fin_reg.nonzero)
                res_next.command_kind = KIND_NUMERIC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_adv)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fin_adv)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // A result only appears after a finished line was held
    a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(fin_valid_reg))
        else $error("result issued without a finished line");

    // A failed parse carries no class and no parts
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.parse_ok)
            |-> (res_reg.command_kind == KIND_OTHER && res_reg.present_mask == 5'd0))
        else $error("failed parse reports fields");

    // The byte flagged last returns the parser to line start
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last) |=> (st_reg.phase == PH_START && st_reg.n == '0 && !seen_reg))
        else $error("parse state not cleared after line end");

    // Kept byte count never passes MAX_LINE-1
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, st_reg.n} < (POS_W + 1)'(MAX_LINE)))
        else $error("byte position out of range");

endmodule

FILE: tb/tb_irc_line_field_splitter.sv
`timescale 1ns / 1ps
// Testbench for irc_line_field_splitter: a table of lines, then random lines.
// Each result is checked against a typed-in value or the line parser in this file.
// Depends on ilsplit_pkg, ilsplit_in_if, ilsplit_out_if and the block.
module tb_irc_line_field_splitter;
    import ilsplit_pkg::*;

    localparam int LINE_MAX     = MAX_LINE_DEF;
    localparam int RANDOM_BYTES = 900;     // random part runs until this many bytes...
    localparam int RANDOM_LINES = 60;      // ...and this many lines have been sent
    localparam int DRAIN_EVERY  = 20;      // lines between full drains of the result path
    localparam int TAIL_CYCLES  = 8;       // clocks to wait after the final drain
    localparam result_req_t NO_PARSE = '0;

    // Table row: text is right aligned, byte 0 of the line is the leftmost of nbytes.
    typedef struct packed {
        logic [383:0] text;
        logic [5:0]   nbytes;
        logic         typed;
        result_req_t  want;
    } line_row_t;

    // One entry per line sent, in order: typed-in result or "use the parser".
    typedef struct packed {
        logic        typed;
        result_req_t want;
    } line_note_t;

    typedef struct packed {
        logic [55:0] text;
        logic [2:0]  size;
        logic [3:0]  kind;
    } keyword_t;

    logic clk = 1'b0;
    logic rst_n;

    ilsplit_in_if  line_bus();
    ilsplit_out_if result_bus();

    irc_line_field_splitter #(
        .MAX_LINE (LINE_MAX)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_bus),
        .result (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line parser. Tracks the bytes kept for the current line and, on the
    // byte flagged last, splits the text into its fields.
    // ------------------------------------------------------------------
    logic [7:0]  line_text [0:LINE_MAX-1];
    int          text_len    = 0;
    bit          text_ended  = 1'b0;    // zero byte seen or line full
    result_req_t expected_results [$];
    line_note_t  line_notes [$];
    int          error_count = 0;

    // Command keywords in match order; kind codes follow the same order.
    function automatic keyword_t keyword(input int k);
        keyword_t w;
        w.text = '0;
        w.size = 3'd4;
        case (k)
            0:       begin w.text = "PING";    w.kind = KIND_PING;    end
            1:       begin w.text = "PRIVMSG"; w.kind = KIND_PRIVMSG; w.size = 3'd7; end
            2:       begin w.text = "NOTICE";  w.kind = KIND_NOTICE;  w.size = 3'd6; end
            3:       begin w.text = "JOIN";    w.kind = KIND_JOIN;    end
            4:       begin w.text = "PART";    w.kind = KIND_PART;    end
            5:       begin w.text = "QUIT";    w.kind = KIND_QUIT;    end
            default: begin w.text = "NICK";    w.kind = KIND_NICK;    end
        endcase
        return w;
    endfunction

    // First index in [from, upto) holding ch, else upto.
    function automatic int find_char(input int from, input int upto, input logic [7:0] ch);
        int i;
        for (i = from; i < upto && i < LINE_MAX; i++)
            if (line_text[i] == ch)
                return i;
        return upto;
    endfunction

    // Numeric when an atoi-style read is nonzero, else first keyword prefix.
    function automatic logic [3:0] classify_command(input int start, input int len);
        int       i;
        int       j;
        bit       nonzero;
        bit       match;
        keyword_t w;
        i = 0;
        nonzero = 1'b0;
        while (i < len && (line_text[start+i] == CH_SPACE ||
                           (line_text[start+i] >= CH_TAB && line_text[start+i] <= CH_CR)))
            i++;
        if (i < len && (line_text[start+i] == CH_PLUS || line_text[start+i] == CH_MINUS))
            i++;
        while (i < len && line_text[start+i] >= CH_ZERO && line_text[start+i] <= CH_NINE)
        begin
            if (line_text[start+i] != CH_ZERO)
                nonzero = 1'b1;
            i++;
        end
        if (nonzero)
            return KIND_NUMERIC;
        for (j = 0; j < KW_COUNT; j++)
        begin
            w = keyword(j);
            match = (len >= w.size);
            for (i = 0; i < w.size && match; i++)
                if (line_text[start+i] != w.text[(w.size-1-i)*8 +: 8])
                    match = 1'b0;
            if (match)
                return w.kind;
        end
        return KIND_OTHER;
    endfunction

    // Splits line_text[0:len-1] into prefix, command, target and message.
    function automatic result_req_t split_line(input int len);
        result_req_t r;
        int          cs, sp, sp2, sp3, t, bang, at_pos;
        int          nick, ul, hl, cl, ts, tl, ms, ml;
        logic [4:0]  mask;
        bit          src;
        r = '0;
        cs = 0; nick = 0; ul = 0; hl = 0; ts = 0; tl = 0; ms = 0; ml = 0;
        mask = '0;
        src = 1'b0;
        if (len > 0 && line_text[0] == CH_COLON)
        begin
            sp = find_char(0, len, CH_SPACE);
            if (sp == len)
                return r;               // prefix with no space after it
            cs = sp + 1;
            src = 1'b1;
            mask[PM_SOURCE] = 1'b1;
            bang = find_char(1, sp, CH_BANG);
            if (bang < sp)
            begin
                nick = bang - 1;
                mask[PM_USER] = 1'b1;
                at_pos = find_char(bang + 1, sp, CH_AT);
                if (at_pos < sp)
                begin
                    ul = at_pos - bang - 1;
                    hl = sp - at_pos - 1;
                    mask[PM_HOST] = 1'b1;
                end
                else
                begin
                    ul = sp - bang - 1;
                end
            end
            else
            begin
                nick = sp - 1;
            end
        end
        sp2 = find_char(cs, len, CH_SPACE);
        if (sp2 == len)
            return r;                   // command with no space after it
        cl = sp2 - cs;
        t = sp2 + 1;
        if (t < len && line_text[t] == CH_COLON)
        begin
            ms = t + 1;
            ml = len - ms;
            mask[PM_MESSAGE] = 1'b1;
        end
        else
        begin
            sp3 = find_char(t, len, CH_SPACE);
            tl = sp3 - t;
            ts = t;
            if (sp3 < len)
            begin
                ms = sp3 + 1;
                if (ms < len && line_text[ms] == CH_COLON)
                    ms++;
                ml = len - ms;
                mask[PM_MESSAGE] = 1'b1;
            end
            if (t < len && line_text[t] == CH_HASH)
            begin
                mask[PM_TARGET] = 1'b1;
            end
            else if (src)
            begin
                // a target that is not a channel is reported as the source
                ts = 1;
                tl = nick;
                mask[PM_TARGET] = 1'b1;
            end
            else
            begin
                ts = 0;
                tl = 0;
            end
        end
        r.parse_ok      = 1'b1;
        r.command_kind  = classify_command(cs, cl);
        r.present_mask  = mask;
        r.nick_len      = FIELD_W'(nick);
        r.user_len      = FIELD_W'(ul);
        r.host_len      = FIELD_W'(hl);
        r.command_start = FIELD_W'(cs);
        r.command_len   = FIELD_W'(cl);
        r.target_start  = FIELD_W'(ts);
        r.target_len    = FIELD_W'(tl);
        r.message_start = FIELD_W'(ms);
        r.message_len   = FIELD_W'(ml);
        return r;
    endfunction

    // Every accepted byte request goes through here.
    always @(posedge clk)
    begin : line_track
        line_note_t note;
        int         cut;
        int         i;
        bit         hit;
        if (rst_n && line_bus.valid && line_bus.ready)
        begin
            if (!text_ended)
            begin
                if (line_bus.data.line_byte == CH_NUL || text_len >= LINE_MAX - 1)
                begin
                    text_ended = 1'b1;
                end
                else
                begin
                    line_text[text_len] = line_bus.data.line_byte;
                    text_len++;
                end
                if (text_len >= LINE_MAX - 1)
                    text_ended = 1'b1;
            end
            if (line_bus.data.line_last)
            begin
                // only the text before the last newline is parsed
                cut = text_len;
                hit = 1'b0;
                for (i = text_len; i > 0 && !hit; i--)
                    if (line_text[i-1] == CH_NL)
                    begin
                        cut = i - 1;
                        hit = 1'b1;
                    end
                note = line_notes.pop_front();
                expected_results.push_back(note.typed ? note.want : split_line(cut));
                text_len = 0;
                text_ended = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    function automatic string field_diffs(input result_req_t got, input result_req_t want);
        string s;
        s = "";
        if (got.parse_ok      !== want.parse_ok)      s = {s, " parse_ok"};
        if (got.command_kind  !== want.command_kind)  s = {s, " command_kind"};
        if (got.present_mask  !== want.present_mask)  s = {s, " present_mask"};
        if (got.nick_len      !== want.nick_len)      s = {s, " nick_len"};
        if (got.user_len      !== want.user_len)      s = {s, " user_len"};
        if (got.host_len      !== want.host_len)      s = {s, " host_len"};
        if (got.command_start !== want.command_start) s = {s, " command_start"};
        if (got.command_len   !== want.command_len)   s = {s, " command_len"};
        if (got.target_start  !== want.target_start)  s = {s, " target_start"};
        if (got.target_len    !== want.target_len)    s = {s, " target_len"};
        if (got.message_start !== want.message_start) s = {s, " message_start"};
        if (got.message_len   !== want.message_len)   s = {s, " message_len"};
        return s;
    endfunction

    task automatic show_result(input string label, input result_req_t r);
        $display("  %s ok=%0d kind=%0d mask=%b nick=%0d user=%0d host=%0d cmd=%0d+%0d tgt=%0d+%0d msg=%0d+%0d",
                 label, r.parse_ok, r.command_kind, r.present_mask, r.nick_len, r.user_len,
                 r.host_len, r.command_start, r.command_len, r.target_start, r.target_len,
                 r.message_start, r.message_len);
    endtask

    always @(posedge clk)
    begin : result_check
        result_req_t want;
        string       diffs;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("%0t: result request with no line pending", $realtime);
                    show_result("actual  ", result_bus.data);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                diffs = field_diffs(result_bus.data, want);
                if (diffs != "")
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: result mismatch in%s", $realtime, diffs);
                        show_result("expected", want);
                        show_result("actual  ", result_bus.data);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: a 16-bit ready pattern, replayed and then
    // redrawn. One epoch in four never stalls.
    // ------------------------------------------------------------------
    initial
    begin : result_stall
        logic [15:0] pattern;
        int          k;
        result_bus.ready = 1'b0;
        forever
        begin
            case ($urandom_range(3))
                0:       pattern = '1;
                1:       pattern = $urandom;
                2:       pattern = $urandom | $urandom;
                default: pattern = $urandom & $urandom;
            endcase
            if (pattern == '0)
                pattern = 16'h0001;
            for (k = 0; k < 48; k++)
            begin
                @(negedge clk);
                result_bus.ready <= pattern[k % 16];
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length with random gaps between them.
    // A steady line sends without any gap.
    // ------------------------------------------------------------------
    int  burst_left = 0;
    bit  steady     = 1'b0;
    logic [7:0] line_bytes [$];

    task automatic send_byte(input logic [7:0] b, input logic last);
        line_req_t req;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = steady ? 0 : $urandom_range(6, 0);
            if (gap > 0)
            begin
                @(negedge clk);
                line_bus.valid <= 1'b0;
                line_bus.data  <= $urandom_range(511, 0);
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        req.line_byte = b;
        req.line_last = last;
        @(negedge clk);
        line_bus.valid <= 1'b1;
        line_bus.data  <= req;
        @(posedge clk);
        while (!line_bus.ready)
            @(posedge clk);
    endtask

    task automatic send_line(input logic typed, input result_req_t want);
        line_note_t note;
        int         i;
        note.typed = typed;
        note.want  = want;
        line_notes.push_back(note);
        for (i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
    endtask

    // Sender holds off until every line has come back as a result.
    task automatic wait_drained();
        @(negedge clk);
        line_bus.valid <= 1'b0;
        while (expected_results.size() != 0 || line_notes.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Random line builder.
    // ------------------------------------------------------------------
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(9))
            0, 1, 2: c = "a" + $urandom_range(25);
            3, 4, 5: c = "A" + $urandom_range(25);
            6:       c = CH_ZERO + $urandom_range(9);
            7:
            begin
                case ($urandom_range(4))
                    0:       c = CH_BANG;
                    1:       c = CH_AT;
                    2:       c = CH_HASH;
                    3:       c = CH_COLON;
                    default: c = CH_MINUS;
                endcase
            end
            default: c = $urandom_range(255, 1);
        endcase
        return c;
    endfunction

    task automatic put_word(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) line_bytes.push_back(word_char());
    endtask

    // Message text: words with spaces between.
    task automatic put_text(input int lo, input int hi);
        repeat ($urandom_range(hi, lo))
            line_bytes.push_back(($urandom_range(5) == 0) ? CH_SPACE : word_char());
    endtask

    task automatic put_keyword(input int k, input int n);
        keyword_t w;
        int       i;
        w = keyword(k);
        for (i = 0; i < n; i++)
            line_bytes.push_back(w.text[(w.size-1-i)*8 +: 8]);
    endtask

    task automatic put_command();
        keyword_t w;
        int       pick;
        int       k;
        pick = $urandom_range(11);
        if (pick < KW_COUNT)
        begin
            w = keyword(pick);
            put_keyword(pick, w.size);
        end
        else
        begin
            case (pick)
                7:
                begin
                    // three digits, all zero now and then
                    if ($urandom_range(3) == 0)
                        repeat (3) line_bytes.push_back(CH_ZERO);
                    else
                        repeat (3) line_bytes.push_back(CH_ZERO + $urandom_range(9));
                end
                8:
                begin
                    // keyword cut short or followed by more letters
                    k = $urandom_range(KW_COUNT - 1);
                    w = keyword(k);
                    put_keyword(k, $urandom_range(w.size));
                    put_word(0, 3);
                end
                9:  put_word(1, 8);
                10:
                begin
                    // leading white space and, at times, a sign before the digits
                    line_bytes.push_back($urandom_range(1) ? CH_TAB : CH_CR);
                    if ($urandom_range(1))
                        line_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                    repeat ($urandom_range(4, 1)) line_bytes.push_back(CH_ZERO + $urandom_range(9));
                end
                default: ;  // empty command
            endcase
        end
    endtask

    task automatic build_line(input int idx);
        int shape;
        line_bytes.delete();
        if (idx % 25 == 12)
        begin
            // long lines, some past the line limit, to push lengths to the top
            line_bytes.push_back(CH_COLON);
            if ((idx / 25) % 2 == 0)
            begin
                put_word(1, 6);
                line_bytes.push_back(CH_BANG);
                put_word(1, 4);
                line_bytes.push_back(CH_AT);
                put_word(1, 8);
                line_bytes.push_back(CH_SPACE);
                put_keyword(1, 7);
                line_bytes.push_back(CH_SPACE);
                line_bytes.push_back(CH_HASH);
                put_word(1, 6);
                line_bytes.push_back(CH_SPACE);
                line_bytes.push_back(CH_COLON);
                put_text(300, 560);
            end
            else
            begin
                repeat ($urandom_range(520, 250)) line_bytes.push_back("a" + $urandom_range(25));
                line_bytes.push_back(CH_SPACE);
                put_keyword(6, 4);
                line_bytes.push_back(CH_SPACE);
                put_word(1, 8);
            end
            return;
        end
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            // noise: any byte value
            repeat ($urandom_range(20, 1)) line_bytes.push_back($urandom_range(255, 0));
            return;
        end
        if ($urandom_range(9) < 7)
        begin
            line_bytes.push_back(CH_COLON);
            put_word(0, 9);
            if ($urandom_range(2) != 0)
            begin
                line_bytes.push_back(CH_BANG);
                put_word(0, 6);
            end
            if ($urandom_range(2) != 0)
            begin
                line_bytes.push_back(CH_AT);
                put_word(0, 10);
            end
            if ($urandom_range(15) != 0)
                line_bytes.push_back(CH_SPACE);
        end
        put_command();
        if ($urandom_range(15) != 0)
        begin
            line_bytes.push_back(CH_SPACE);
            case ($urandom_range(4))
                0:  ;
                1:
                begin
                    line_bytes.push_back(CH_COLON);
                    put_text(0, 20);
                end
                2:
                begin
                    line_bytes.push_back(CH_HASH);
                    put_word(0, 8);
                end
                3:  put_word(1, 8);
                default:
                begin
                    line_bytes.push_back(CH_HASH);
                    put_word(0, 8);
                    line_bytes.push_back(CH_SPACE);
                    if ($urandom_range(1))
                        line_bytes.push_back(CH_COLON);
                    put_text(0, 24);
                end
            endcase
            if ($urandom_range(2) == 0)
            begin
                line_bytes.push_back(CH_SPACE);
                if ($urandom_range(1))
                    line_bytes.push_back(CH_COLON);
                put_text(0, 24);
            end
        end
        if ($urandom_range(11) == 0)
        begin
            line_bytes.push_back(CH_NL);
            put_text(0, 10);
        end
        if (line_bytes.size() == 0)
            line_bytes.push_back(word_char());
        // broken lines: a byte replaced, a zero byte dropped in
        if (shape == 1)
            line_bytes[$urandom_range(line_bytes.size() - 1)] = word_char();
        if ($urandom_range(24) == 0)
            line_bytes[$urandom_range(line_bytes.size() - 1)] = CH_NUL;
    endtask

    // ------------------------------------------------------------------
    // Directed lines. Rows whose result is plain to see carry it typed in;
    // the rest go through the parser above.
    // ------------------------------------------------------------------
    line_row_t directed_rows [$];

    task automatic add_row(input logic [383:0] text, input int n, input logic typed,
                           input result_req_t want);
        line_row_t row;
        row.text   = text;
        row.nbytes = n;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    initial
    begin : stimulus
        result_req_t bare_command;
        line_row_t   row;
        int          r;
        int          i;
        int          line_count;
        int          random_bytes;

        line_bus.valid = 1'b0;
        line_bus.data  = '0;
        rst_n = 1'b0;

        // "A ": command of one letter, nothing else present
        bare_command = '0;
        bare_command.parse_ok    = 1'b1;
        bare_command.command_len = 1;

        // full prefix, channel target, colon message
        add_row(":nick!user@host PRIVMSG #chan :hello", 36, 1'b0, NO_PARSE);
        // numeric reply, nick target replaced by the source
        add_row(":srv 001 me :Welcome", 20, 1'b0, NO_PARSE);
        add_row("PING :abc", 9, 1'b0, NO_PARSE);
        // non-channel target with no source: target absent
        add_row("NOTICE x y", 10, 1'b0, NO_PARSE);
        add_row(":a!b NOTICE #c", 14, 1'b0, NO_PARSE);
        add_row("JOIN #x", 7, 1'b0, NO_PARSE);
        add_row("PART #x :bye", 12, 1'b0, NO_PARSE);
        add_row("QUIT :gone", 10, 1'b0, NO_PARSE);
        add_row(":n NICK newnick", 15, 1'b0, NO_PARSE);
        // PART matched on its four letters only
        add_row("PARTY a", 7, 1'b0, NO_PARSE);
        // sign, zeros and digits; all-zero numbers are not numeric
        add_row("-0012 x", 7, 1'b0, NO_PARSE);
        add_row("+000 x", 6, 1'b0, NO_PARSE);
        add_row({8'h09, "42 x"}, 5, 1'b0, NO_PARSE);
        // command that begins with a space is empty
        add_row(" x y", 4, 1'b0, NO_PARSE);
        // missing spaces: prefix alone, command alone
        add_row(":nick", 5, 1'b1, NO_PARSE);
        add_row("PING", 4, 1'b1, NO_PARSE);
        // zero byte: empty text, and text cut before the space
        add_row({8'h00}, 1, 1'b1, NO_PARSE);
        add_row({"PING", 8'h00, " x"}, 7, 1'b1, NO_PARSE);
        // newlines: text after the last one is dropped
        add_row({"JOIN #a", 8'h0A, "junk"}, 12, 1'b0, NO_PARSE);
        add_row({":x NICK y", 8'h0A, "A B", 8'h0A, "zz"}, 16, 1'b0, NO_PARSE);
        // near misses of keywords
        add_row("PRIVMS x", 8, 1'b0, NO_PARSE);
        add_row("ping x", 6, 1'b0, NO_PARSE);
        // message without colon, empty message, nothing after the command
        add_row("A B C", 5, 1'b0, NO_PARSE);
        add_row("A :", 3, 1'b0, NO_PARSE);
        add_row("A ", 2, 1'b1, bare_command);
        // empty nick, user and host
        add_row(":!@ X Y", 7, 1'b0, NO_PARSE);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < directed_rows.size(); r++)
        begin
            row = directed_rows[r];
            line_bytes.delete();
            for (i = 0; i < row.nbytes; i++)
                line_bytes.push_back(row.text[(row.nbytes-1-i)*8 +: 8]);
            send_line(row.typed, row.want);
        end
        wait_drained();

        // random lines; every so often the sender waits for a full drain
        line_count = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES || line_count < RANDOM_LINES)
        begin
            build_line(line_count);
            steady = ($urandom_range(4) == 0);
            random_bytes += line_bytes.size();
            send_line(1'b0, NO_PARSE);
            line_count++;
            if (line_count % DRAIN_EVERY == 0)
                wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin : run_limit
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
